// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the timer bank; they sample on clk_i and are
// held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a full property, clocked and reset-gated
`define PTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// same-cycle implication
`define PTB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Types and constants of the periodic timer bank.
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int unsigned TIMER_COUNT_DEF = 4;
  localparam int unsigned TIMER_ID_W      = 4;
  localparam int unsigned MS_W            = 48;
  localparam int unsigned PERIOD_W        = 32;
  localparam int unsigned CI_W            = 10;
  localparam int unsigned DW_W            = 16;
  localparam int unsigned CFG_W           = 16;

  localparam logic [CI_W-1:0] CHECK_INTERVAL_RST = 10'd1000;
  localparam logic [DW_W-1:0] DEFAULT_WAIT_RST   = 16'd100;

  typedef enum logic [2:0] {
    MODE_TICK        = 3'd0,
    MODE_SET_PERIOD  = 3'd1,
    MODE_SET_LEFT    = 3'd2,
    MODE_READ_PERIOD = 3'd3,
    MODE_READ_LEFT   = 3'd4,
    MODE_CHECK       = 3'd5,
    MODE_WAIT        = 3'd6
  } mode_e;

  typedef enum logic {
    CFG_CHECK_INTERVAL = 1'b0,
    CFG_DEFAULT_WAIT   = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [MS_W-1:0]     deadline;
  } entry_t;

  typedef struct packed {
    mode_e mode;
    logic  sel;
  } unit_ctl_t;

  typedef struct packed {
    logic                   fire;
    logic [PERIOD_W-1:0]    rd_val;
    logic signed [MS_W-1:0] best;
  } unit_stat_t;

endpackage

// File: rtl/ptb_cell.sv
// ----------------------------------------------------------------------------
// ptb_cell
// One timer slot of the rotating chain: period and deadline, loaded from the
// neighbor whenever the chain shifts.
// ----------------------------------------------------------------------------
module ptb_cell
  import ptb_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_i,
  input  entry_t entry_i,
  output entry_t entry_o
);

  entry_t entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule

// File: rtl/ptb_unit.sv
// ----------------------------------------------------------------------------
// ptb_unit
// Head unit of the chain: works on the timer at the head cell for the
// current operation and hands the updated entry to the tail.
// ----------------------------------------------------------------------------
module ptb_unit
  import ptb_pkg::*;
(
  input  unit_ctl_t              ctl_i,
  input  entry_t                 entry_i,
  input  logic [MS_W-1:0]        now_i,
  input  logic [PERIOD_W-1:0]    wv_i,
  input  logic signed [MS_W-1:0] best_i,
  output entry_t                 entry_o,
  output unit_stat_t             stat_o
);

  logic                active;
  logic [PERIOD_W-1:0] addend;
  logic [MS_W-1:0]     sum;
  logic [MS_W:0]       diff;
  logic                borrow;
  logic                due;
  logic [PERIOD_W-1:0] left;

  always_comb begin
    active = (entry_i.period != '0);
    // one adder: reload on check, written value otherwise
    addend = (ctl_i.mode == MODE_CHECK) ? entry_i.period : wv_i;
    sum    = now_i + MS_W'(addend);
    diff   = {1'b0, entry_i.deadline} - {1'b0, now_i};
    borrow = diff[MS_W];
    due    = borrow || (diff[MS_W-1:0] == '0);
    if (borrow || !active) begin
      left = '0;
    end else if (|diff[MS_W-1:PERIOD_W]) begin
      left = '1;
    end else begin
      left = diff[PERIOD_W-1:0];
    end
  end

  always_comb begin
    entry_o       = entry_i;
    stat_o.fire   = 1'b0;
    stat_o.rd_val = '0;
    stat_o.best   = best_i;
    unique case (ctl_i.mode)
      MODE_SET_PERIOD: begin
        if (ctl_i.sel) begin
          entry_o.period = wv_i;
          if (wv_i != '0) begin
            entry_o.deadline = sum;
          end
        end
      end
      MODE_SET_LEFT: begin
        if (ctl_i.sel) begin
          entry_o.deadline = sum;
        end
      end
      MODE_READ_PERIOD: begin
        stat_o.rd_val = ctl_i.sel ? entry_i.period : '0;
      end
      MODE_READ_LEFT: begin
        stat_o.rd_val = ctl_i.sel ? left : '0;
      end
      MODE_CHECK: begin
        if (active && due) begin
          entry_o.deadline = sum;
          stat_o.fire      = 1'b1;
        end
      end
      MODE_WAIT: begin
        if (active && ($signed(diff[MS_W-1:0]) < best_i)) begin
          stat_o.best = $signed(diff[MS_W-1:0]);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/periodic_timer_bank_top.sv
// ----------------------------------------------------------------------------
// periodic_timer_bank_top
// Bank of periodic millisecond timers kept in a rotating chain of cells.
// ----------------------------------------------------------------------------
// The timers sit in a ring of TIMER_COUNT cells that rotates past a single
// head unit, one timer per cycle. A tick, an unused mode or a check that does
// not yet scan is taken without leaving the idle state. Every other item
// rotates the whole ring once, then goes through the flush state before the
// next beat. An item with a result holds in its last cycle until the output
// register is free, and a check that fires more than one timer holds the ring
// the same way at each fired timer after the first. Results are held in an
// output register, so a new item is taken while the last result still waits.
`include "assert_macros.svh"

module periodic_timer_bank_top
  import ptb_pkg::*;
#(
  parameter int unsigned TIMER_COUNT = TIMER_COUNT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0]             mode_i,
  input  logic [TIMER_ID_W-1:0]  timer_id_i,
  input  logic [PERIOD_W-1:0]    write_value_i,
  input  logic                   forced_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [PERIOD_W-1:0]    read_value_o,
  output logic signed [31:0]     next_wait_o,
  output logic                   irq_valid_o,
  output logic [TIMER_ID_W-1:0]  irq_timer_o,
  output logic                   last_o
);

  localparam int unsigned IdxW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TIMER_COUNT - 1);

  state_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [MS_W-1:0] now_q;
  logic [CI_W-1:0] cnt_q, ci_q;
  logic [DW_W-1:0] dw_q;
  mode_e mode_q;
  logic [TIMER_ID_W-1:0] id_q;
  logic [PERIOD_W-1:0] wv_q;
  logic pend_valid_q;
  logic [IdxW-1:0] pend_id_q;
  logic [PERIOD_W-1:0] rd_q;
  logic signed [MS_W-1:0] best_q;

  logic out_valid_q;
  logic [PERIOD_W-1:0] out_rv_q, out_rv_d;
  logic signed [31:0] out_nw_q, out_nw_d;
  logic out_irq_q, out_irq_d;
  logic [TIMER_ID_W-1:0] out_tid_q, out_tid_d;
  logic out_last_q, out_last_d;

  entry_t cell_out [TIMER_COUNT];
  entry_t head_new;
  unit_ctl_t ctl;
  unit_stat_t stat;

  mode_e mode_in;
  logic in_acc, start_scan, scan_now;
  logic [CI_W-1:0] cnt_inc;
  logic out_free, stall, step, flush_emit, out_load, is_read;
  logic signed [31:0] best_sat;

  // rotating chain: head is cell 0, updated head entry re-enters at the tail
  for (genvar k = 0; k < TIMER_COUNT; k++) begin : g_cell
    if (k == TIMER_COUNT - 1) begin : g_tail
      ptb_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (step),
        .entry_i (head_new),
        .entry_o (cell_out[k])
      );
    end else begin : g_body
      ptb_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (step),
        .entry_i (cell_out[k+1]),
        .entry_o (cell_out[k])
      );
    end
  end

  assign ctl.mode = mode_q;
  assign ctl.sel  = (TIMER_ID_W'(idx_q) == id_q);

  ptb_unit u_unit (
    .ctl_i   (ctl),
    .entry_i (cell_out[0]),
    .now_i   (now_q),
    .wv_i    (wv_q),
    .best_i  (best_q),
    .entry_o (head_new),
    .stat_o  (stat)
  );

  // decode of the incoming beat
  always_comb begin
    mode_in  = mode_e'(mode_i);
    in_acc   = in_valid_i && (state_q == ST_IDLE);
    cnt_inc  = cnt_q + 1'b1;
    scan_now = forced_i || (cnt_inc >= ci_q);
    unique case (mode_in)
      MODE_SET_PERIOD, MODE_SET_LEFT, MODE_READ_PERIOD,
      MODE_READ_LEFT, MODE_WAIT: start_scan = 1'b1;
      MODE_CHECK:                start_scan = scan_now;
      default:                   start_scan = 1'b0;
    endcase
  end

  always_comb begin
    is_read  = (mode_q == MODE_READ_PERIOD) || (mode_q == MODE_READ_LEFT);
    out_free = !out_valid_q || out_ready_i;
    // a second fired timer needs the earlier one pushed out first
    stall    = stat.fire && pend_valid_q && !out_free;
    step     = (state_q == ST_SCAN) && !stall;
    flush_emit = is_read || (mode_q == MODE_WAIT) || pend_valid_q;
    if (best_q[MS_W-1] && !(&best_q[MS_W-1:31])) begin
      best_sat = 32'sh8000_0000;
    end else if (!best_q[MS_W-1] && (|best_q[MS_W-1:31])) begin
      best_sat = 32'sh7fff_ffff;
    end else begin
      best_sat = best_q[31:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && start_scan) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (step && (idx_q == LastIdx)) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!flush_emit || out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    idx_d      = idx_q;
    out_load   = 1'b0;
    out_rv_d   = '0;
    out_nw_d   = '0;
    out_irq_d  = 1'b0;
    out_tid_d  = '0;
    out_last_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
      end
      ST_SCAN: begin
        if (step) begin
          idx_d = idx_q + 1'b1;
          if (stat.fire && pend_valid_q) begin
            out_load  = 1'b1;
            out_irq_d = 1'b1;
            out_tid_d = TIMER_ID_W'(pend_id_q);
          end
        end
      end
      ST_FLUSH: begin
        if (flush_emit && out_free) begin
          out_load   = 1'b1;
          out_rv_d   = rd_q;
          out_nw_d   = (mode_q == MODE_WAIT) ? best_sat : '0;
          out_irq_d  = (mode_q == MODE_CHECK);
          out_tid_d  = (mode_q == MODE_CHECK) ? TIMER_ID_W'(pend_id_q) : '0;
          out_last_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      now_q        <= '0;
      cnt_q        <= '0;
      ci_q         <= CHECK_INTERVAL_RST;
      dw_q         <= DEFAULT_WAIT_RST;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_CHECK_INTERVAL: ci_q <= cfg_data_i[CI_W-1:0];
          CFG_DEFAULT_WAIT:   dw_q <= cfg_data_i[DW_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        if (mode_in == MODE_TICK) begin
          now_q <= now_q + 1'b1;
        end
        if (mode_in == MODE_CHECK) begin
          cnt_q <= scan_now ? '0 : cnt_inc;
        end
        pend_valid_q <= 1'b0;
      end else if (step && stat.fire) begin
        pend_valid_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item payload and scan accumulators
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= mode_in;
      id_q   <= timer_id_i;
      wv_q   <= write_value_i;
      rd_q   <= '0;
      best_q <= MS_W'(dw_q);
    end else if (step) begin
      if (ctl.sel && is_read) begin
        rd_q <= stat.rd_val;
      end
      best_q <= stat.best;
      if (stat.fire) begin
        pend_id_q <= idx_q;
      end
    end
    if (out_load) begin
      out_rv_q   <= out_rv_d;
      out_nw_q   <= out_nw_d;
      out_irq_q  <= out_irq_d;
      out_tid_q  <= out_tid_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_rv_q;
  assign next_wait_o  = out_nw_q;
  assign irq_valid_o  = out_irq_q;
  assign irq_timer_o  = out_tid_q;
  assign last_o       = out_last_q;

  // a stalled scan keeps the ring where it is
  `PTB_ASSERT(a_stall_holds, (state_q == ST_SCAN && stall) |=> (state_q == ST_SCAN && $stable(idx_q)), "ring moved during output stall")
  // a pending interrupt only appears from a scan step
  `PTB_ASSERT_IMP(a_pend_from_scan, $rose(pend_valid_q), $past(state_q) == ST_SCAN, "pending irq outside scan")
  // a scan only starts on an accepted beat
  `PTB_ASSERT_IMP(a_scan_entry, state_q == ST_SCAN && $past(state_q) == ST_IDLE, $past(in_valid_i && in_ready_o), "scan without accepted beat")

endmodule
